[src/tphf_pkg.sv]
// ----------------------------------------------------------------------------
// Triangle plane package
// Widths, pipeline stage indexes and shared types for the plane unit.
// ----------------------------------------------------------------------------
package tphf_pkg;

   localparam int COORD_W    = 32;
   localparam int EDGE_W     = COORD_W + 1;
   localparam int PROD_W     = 2 * EDGE_W;
   localparam int CROSS_W    = PROD_W + 1;
   localparam int MAG_W      = PROD_W;
   localparam int HALF_W     = MAG_W / 2;
   localparam int HLEN_W     = 6;
   localparam int LEN_W      = 7;
   localparam int VEC_W      = 31;
   localparam int SQ_W       = 2 * VEC_W;
   localparam int SUM_W      = 64;
   localparam int ROOT_W     = SUM_W / 2;
   localparam int SQ_REM_W   = ROOT_W + 1;
   localparam int QUO_W      = 32;
   localparam int FRAC_SHIFT = 30;
   localparam int DIVD_W     = VEC_W + FRAC_SHIFT + 1;
   localparam int ACC_W      = 64;
   localparam int RND_W      = ACC_W - FRAC_SHIFT + 1;

   // stage indexes along the side line
   localparam int K_NEG    = 3;
   localparam int K_DEG    = 6;
   localparam int K_VEC    = 7;
   localparam int K_SUM    = 9;
   localparam int K_DIVIN  = K_SUM + ROOT_W + 1;
   localparam int K_MUL    = K_DIVIN + QUO_W + 1;
   localparam int K_ACC    = K_MUL + 1;
   localparam int LINE_LEN = K_ACC + 1;
   localparam int LATENCY  = LINE_LEN + 1;

   typedef struct packed {
      logic [2:0][COORD_W-1:0] a;
      logic [2:0]              neg;
      logic                    deg;
      logic [2:0][VEC_W-1:0]   v;
   } side_type;

endpackage

[src/tphf_sqrt.sv]
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per stage; floor(sqrt(radicand)) after ROOT_W stages.
// ----------------------------------------------------------------------------
module tphf_sqrt (
   input  logic                          clock,
   input  logic [tphf_pkg::SUM_W-1:0]    radicand,
   output logic [tphf_pkg::ROOT_W-1:0]   root
);

   localparam int NS    = tphf_pkg::ROOT_W;
   localparam int CUR_W = tphf_pkg::SQ_REM_W + 2;

   logic [tphf_pkg::SQ_REM_W-1:0] rem_ff  [NS];
   logic [tphf_pkg::SQ_REM_W-1:0] rem_in  [NS];
   logic [tphf_pkg::ROOT_W-1:0]   root_ff [NS];
   logic [tphf_pkg::ROOT_W-1:0]   root_in [NS];
   logic [tphf_pkg::SUM_W-1:0]    rad_ff  [NS];
   logic [tphf_pkg::SUM_W-1:0]    rad_in  [NS];

   logic [tphf_pkg::SQ_REM_W-1:0] rem_src  [NS];
   logic [tphf_pkg::ROOT_W-1:0]   root_src [NS];
   logic [tphf_pkg::SUM_W-1:0]    rad_src  [NS];
   logic [CUR_W-1:0]              cur      [NS];
   logic [CUR_W-1:0]              trial    [NS];
   logic [CUR_W-1:0]              diff     [NS];

   always_comb begin
      rem_src[0]  = '0;
      root_src[0] = '0;
      rad_src[0]  = radicand;
      for (int k = 1; k < NS; k++) begin
         rem_src[k]  = rem_ff[k-1];
         root_src[k] = root_ff[k-1];
         rad_src[k]  = rad_ff[k-1];
      end
      for (int k = 0; k < NS; k++) begin
         cur[k]    = {rem_src[k], rad_src[k][tphf_pkg::SUM_W-1 -: 2]};
         trial[k]  = {1'b0, root_src[k], 2'b01};
         diff[k]   = cur[k] - trial[k];
         rad_in[k] = rad_src[k] << 2;
         if (cur[k] >= trial[k]) begin
            rem_in[k]  = diff[k][tphf_pkg::SQ_REM_W-1:0];
            root_in[k] = {root_src[k][tphf_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = cur[k][tphf_pkg::SQ_REM_W-1:0];
            root_in[k] = {root_src[k][tphf_pkg::ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NS; k++) begin
         rem_ff[k]  <= rem_in[k];
         root_ff[k] <= root_in[k];
         rad_ff[k]  <= rad_in[k];
      end
   end

   assign root = root_ff[NS-1];

endmodule

[src/tphf_div.sv]
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage; the quotient must fit in QUO_W bits.
// ----------------------------------------------------------------------------
module tphf_div (
   input  logic                          clock,
   input  logic [tphf_pkg::DIVD_W-1:0]   dividend,
   input  logic [tphf_pkg::ROOT_W-1:0]   divisor,
   output logic [tphf_pkg::QUO_W-1:0]    quotient
);

   localparam int NS = tphf_pkg::QUO_W;
   localparam int RW = tphf_pkg::ROOT_W;

   logic [RW-1:0] rem_ff [NS];
   logic [RW-1:0] rem_in [NS];
   logic [NS-1:0] low_ff [NS];
   logic [NS-1:0] low_in [NS];
   logic [NS-1:0] quo_ff [NS];
   logic [NS-1:0] quo_in [NS];
   logic [RW-1:0] dvs_ff [NS];
   logic [RW-1:0] dvs_in [NS];

   logic [RW-1:0] rem_src [NS];
   logic [NS-1:0] low_src [NS];
   logic [NS-1:0] quo_src [NS];
   logic [RW-1:0] dvs_src [NS];
   logic [RW:0]   cur     [NS];
   logic [RW:0]   diff    [NS];

   always_comb begin
      rem_src[0] = RW'(dividend[tphf_pkg::DIVD_W-1:NS]);
      low_src[0] = dividend[NS-1:0];
      quo_src[0] = '0;
      dvs_src[0] = divisor;
      for (int k = 1; k < NS; k++) begin
         rem_src[k] = rem_ff[k-1];
         low_src[k] = low_ff[k-1];
         quo_src[k] = quo_ff[k-1];
         dvs_src[k] = dvs_ff[k-1];
      end
      for (int k = 0; k < NS; k++) begin
         cur[k]    = {rem_src[k], low_src[k][NS-1]};
         diff[k]   = cur[k] - {1'b0, dvs_src[k]};
         low_in[k] = low_src[k] << 1;
         dvs_in[k] = dvs_src[k];
         if (cur[k] >= {1'b0, dvs_src[k]}) begin
            rem_in[k] = diff[k][RW-1:0];
            quo_in[k] = {quo_src[k][NS-2:0], 1'b1};
         end else begin
            rem_in[k] = cur[k][RW-1:0];
            quo_in[k] = {quo_src[k][NS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NS; k++) begin
         rem_ff[k] <= rem_in[k];
         low_ff[k] <= low_in[k];
         quo_ff[k] <= quo_in[k];
         dvs_ff[k] <= dvs_in[k];
      end
   end

   assign quotient = quo_ff[NS-1];

endmodule

[src/triangle_plane_hessian_form.sv]
// ----------------------------------------------------------------------------
// Triangle plane in Hessian normal form
// Unit normal (Q2.30) and saturated offset (Q16.16) of a triangle plane.
//
//   channel   ports                    handshake
//   request   req_a_x .. req_c_z       start, taken when busy is low
//   response  rsp_normal_*, rsp_plane_ rsp_strobe, one cycle, no backpressure
//             offset, rsp_degenerate
//
// One word enters per cycle while busy is low; results leave in the order of their words.
// Most of the latency lies in the 32-stage square root and the 32-stage dividers.
// busy is high only during reset; reset clears the valid bits only.
// The pipeline never stalls since the receiver takes every result.
// ----------------------------------------------------------------------------
module triangle_plane_hessian_form (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic signed [31:0]  req_a_x,
   input  logic signed [31:0]  req_a_y,
   input  logic signed [31:0]  req_a_z,
   input  logic signed [31:0]  req_b_x,
   input  logic signed [31:0]  req_b_y,
   input  logic signed [31:0]  req_b_z,
   input  logic signed [31:0]  req_c_x,
   input  logic signed [31:0]  req_c_y,
   input  logic signed [31:0]  req_c_z,
   output logic                rsp_strobe,
   output logic signed [31:0]  rsp_normal_x,
   output logic signed [31:0]  rsp_normal_y,
   output logic signed [31:0]  rsp_normal_z,
   output logic signed [31:0]  rsp_plane_offset,
   output logic                rsp_degenerate
);

   localparam int CW = tphf_pkg::COORD_W;
   localparam int EW = tphf_pkg::EDGE_W;
   localparam int PW = tphf_pkg::PROD_W;
   localparam int XW = tphf_pkg::CROSS_W;
   localparam int MW = tphf_pkg::MAG_W;
   localparam int HW = tphf_pkg::HALF_W;
   localparam int LL = tphf_pkg::LINE_LEN;

   function automatic logic [tphf_pkg::HLEN_W-1:0] bit_len(input logic [HW-1:0] w);
      logic [tphf_pkg::HLEN_W-1:0] n;
      n = '0;
      for (int i = 0; i < HW; i++) begin
         if (w[i]) n = tphf_pkg::HLEN_W'(i + 1);
      end
      return n;
   endfunction

   logic                 accept;
   logic [LL-1:0]        vld_ff;
   tphf_pkg::side_type   line_ff [LL];
   tphf_pkg::side_type   line_in [LL];

   logic signed [EW-1:0] e1_ff [3];
   logic signed [EW-1:0] e2_ff [3];
   logic signed [PW-1:0] prod_ff [6];
   logic signed [XW-1:0] cross_ff [3];
   logic [MW-1:0]        mag_ff [3];
   logic [MW-1:0]        mag5_ff [3];
   logic [MW-1:0]        mag6_ff [3];
   logic [MW-1:0]        mag7_ff [3];
   logic [MW-1:0]        orw_ff;
   logic [tphf_pkg::HLEN_W-1:0] hlen_ff;
   logic [tphf_pkg::HLEN_W-1:0] llen_ff;
   logic [tphf_pkg::LEN_W-1:0]  len_ff;
   logic [tphf_pkg::LEN_W-1:0]  len_in;
   logic [MW-1:0]               shifted [3];
   logic [tphf_pkg::VEC_W-1:0]  v_in [3];
   logic [tphf_pkg::SQ_W-1:0]   sq_ff [3];
   logic [tphf_pkg::SUM_W-1:0]  sum_ff;
   logic [tphf_pkg::ROOT_W-1:0] root;
   logic [tphf_pkg::DIVD_W-1:0] dvd_ff [3];
   logic [tphf_pkg::ROOT_W-1:0] dvs_ff;
   logic [tphf_pkg::QUO_W-1:0]  quo [3];
   logic signed [CW-1:0]        u_in [3];
   logic signed [CW-1:0]        u_ff [3];
   logic signed [CW-1:0]        u2_ff [3];
   logic signed [tphf_pkg::ACC_W-1:0] mul_ff [3];
   logic signed [tphf_pkg::ACC_W-1:0] acc_ff;
   logic [tphf_pkg::ACC_W-1:0]  acc_mag;
   logic [tphf_pkg::RND_W-1:0]  rnd;
   logic [tphf_pkg::RND_W-1:0]  m;
   logic [CW-1:0]               offset_in;
   logic                        deg_out;

   logic                 strobe_ff;
   logic signed [CW-1:0] nx_ff, ny_ff, nz_ff, off_ff;
   logic                 deg_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   // side line: vertex a, signs, degenerate flag and scaled vector
   always_comb begin
      line_in[0].a   = {req_a_z, req_a_y, req_a_x};
      line_in[0].neg = '0;
      line_in[0].deg = 1'b0;
      line_in[0].v   = '0;
      for (int k = 1; k < LL; k++) line_in[k] = line_ff[k-1];
      for (int i = 0; i < 3; i++) line_in[tphf_pkg::K_NEG].neg[i] = cross_ff[i][XW-1];
      line_in[tphf_pkg::K_DEG].deg = (len_in == '0);
      for (int i = 0; i < 3; i++) line_in[tphf_pkg::K_VEC].v[i] = v_in[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         vld_ff    <= {vld_ff[LL-2:0], accept};
         strobe_ff <= vld_ff[LL-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < LL; k++) line_ff[k] <= line_in[k];
   end

   // edges, cross product, magnitudes
   always_ff @(posedge clock) begin
      e1_ff[0] <= EW'(req_b_x) - EW'(req_a_x);
      e1_ff[1] <= EW'(req_b_y) - EW'(req_a_y);
      e1_ff[2] <= EW'(req_b_z) - EW'(req_a_z);
      e2_ff[0] <= EW'(req_c_x) - EW'(req_a_x);
      e2_ff[1] <= EW'(req_c_y) - EW'(req_a_y);
      e2_ff[2] <= EW'(req_c_z) - EW'(req_a_z);

      prod_ff[0] <= PW'(e1_ff[1]) * PW'(e2_ff[2]);
      prod_ff[1] <= PW'(e1_ff[2]) * PW'(e2_ff[1]);
      prod_ff[2] <= PW'(e1_ff[2]) * PW'(e2_ff[0]);
      prod_ff[3] <= PW'(e1_ff[0]) * PW'(e2_ff[2]);
      prod_ff[4] <= PW'(e1_ff[0]) * PW'(e2_ff[1]);
      prod_ff[5] <= PW'(e1_ff[1]) * PW'(e2_ff[0]);

      for (int i = 0; i < 3; i++) begin
         cross_ff[i] <= XW'(prod_ff[2*i]) - XW'(prod_ff[2*i+1]);
         mag_ff[i]   <= cross_ff[i][XW-1] ? MW'(-cross_ff[i]) : MW'(cross_ff[i]);
         mag5_ff[i]  <= mag_ff[i];
         mag6_ff[i]  <= mag5_ff[i];
         mag7_ff[i]  <= mag6_ff[i];
      end
      orw_ff  <= mag_ff[0] | mag_ff[1] | mag_ff[2];
      hlen_ff <= bit_len(orw_ff[MW-1:HW]);
      llen_ff <= bit_len(orw_ff[HW-1:0]);
      len_ff  <= len_in;
   end

   always_comb begin
      if (hlen_ff != '0) len_in = tphf_pkg::LEN_W'(hlen_ff) + tphf_pkg::LEN_W'(HW);
      else len_in = tphf_pkg::LEN_W'(llen_ff);
   end

   // scale so the largest component is 31 bits long
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (len_ff > tphf_pkg::LEN_W'(tphf_pkg::VEC_W))
            shifted[i] = mag7_ff[i] >> (len_ff - tphf_pkg::LEN_W'(tphf_pkg::VEC_W));
         else
            shifted[i] = mag7_ff[i] << (tphf_pkg::LEN_W'(tphf_pkg::VEC_W) - len_ff);
         v_in[i] = shifted[i][tphf_pkg::VEC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         sq_ff[i] <= tphf_pkg::SQ_W'(line_ff[tphf_pkg::K_VEC].v[i])
                   * tphf_pkg::SQ_W'(line_ff[tphf_pkg::K_VEC].v[i]);
      end
      sum_ff <= tphf_pkg::SUM_W'(sq_ff[0]) + tphf_pkg::SUM_W'(sq_ff[1])
              + tphf_pkg::SUM_W'(sq_ff[2]);
   end

   tphf_sqrt u_sqrt (
      .clock    (clock),
      .radicand (sum_ff),
      .root     (root)
   );

   // dividend carries the half-root rounding term
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         dvd_ff[i] <= tphf_pkg::DIVD_W'({line_ff[tphf_pkg::K_DIVIN-1].v[i],
                                         {tphf_pkg::FRAC_SHIFT{1'b0}}})
                    + tphf_pkg::DIVD_W'(root[tphf_pkg::ROOT_W-1:1]);
      end
      dvs_ff <= root;
   end

   for (genvar g = 0; g < 3; g++) begin : g_div
      tphf_div u_div (
         .clock    (clock),
         .dividend (dvd_ff[g]),
         .divisor  (dvs_ff),
         .quotient (quo[g])
      );
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         u_in[i] = line_ff[tphf_pkg::K_MUL-1].neg[i] ? -$signed(quo[i]) : $signed(quo[i]);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         u_ff[i]   <= u_in[i];
         u2_ff[i]  <= u_ff[i];
         mul_ff[i] <= tphf_pkg::ACC_W'($signed(line_ff[tphf_pkg::K_MUL-1].a[i]))
                    * tphf_pkg::ACC_W'(u_in[i]);
      end
      acc_ff <= mul_ff[0] + mul_ff[1] + mul_ff[2];
   end

   // round magnitude half away from zero, then saturate the negated value
   always_comb begin
      acc_mag = acc_ff[tphf_pkg::ACC_W-1] ? -acc_ff : acc_ff;
      rnd     = tphf_pkg::RND_W'(acc_mag >> tphf_pkg::FRAC_SHIFT)
              + tphf_pkg::RND_W'(acc_mag[tphf_pkg::FRAC_SHIFT-1]);
      m       = rnd;
      if (acc_ff[tphf_pkg::ACC_W-1]) begin
         if (m > tphf_pkg::RND_W'(32'h7FFF_FFFF)) offset_in = 32'h7FFF_FFFF;
         else offset_in = m[CW-1:0];
      end else begin
         if (m > tphf_pkg::RND_W'(32'h8000_0000)) offset_in = 32'h8000_0000;
         else offset_in = -m[CW-1:0];
      end
      deg_out = line_ff[LL-1].deg;
   end

   always_ff @(posedge clock) begin
      deg_ff <= deg_out;
      nx_ff  <= deg_out ? '0 : u2_ff[0];
      ny_ff  <= deg_out ? '0 : u2_ff[1];
      nz_ff  <= deg_out ? '0 : u2_ff[2];
      off_ff <= deg_out ? '0 : offset_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_normal_x     = nx_ff;
   assign rsp_normal_y     = ny_ff;
   assign rsp_normal_z     = nz_ff;
   assign rsp_plane_offset = off_ff;
   assign rsp_degenerate   = deg_ff;

   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe == $past(start && !busy, tphf_pkg::LATENCY))
      else $error("result strobe out of step with accepted words");

   a_deg_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_degenerate |-> rsp_normal_x == 0 && rsp_normal_y == 0
                                       && rsp_normal_z == 0 && rsp_plane_offset == 0)
      else $error("degenerate result carries nonzero fields");

   a_unit_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_degenerate |->
         rsp_normal_x != 0 || rsp_normal_y != 0 || rsp_normal_z != 0)
      else $error("zero normal on a proper triangle");

endmodule

[test/triangle_plane_hessian_form_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle plane unit testbench
// Streams triangles into the plane unit and checks each unit normal, plane
// offset and degenerate flag against a bit-exact fixed-point plane solver.
// ----------------------------------------------------------------------------
module triangle_plane_hessian_form_tb;

   typedef struct {
      logic signed [31:0] v [9];
   } triangle_type;

   typedef struct {
      logic signed [31:0] nx;
      logic signed [31:0] ny;
      logic signed [31:0] nz;
      logic signed [31:0] offset;
      logic               deg;
   } plane_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [31:0] req_a_x, req_a_y, req_a_z;
   logic signed [31:0] req_b_x, req_b_y, req_b_z;
   logic signed [31:0] req_c_x, req_c_y, req_c_z;
   logic               rsp_strobe;
   logic signed [31:0] rsp_normal_x, rsp_normal_y, rsp_normal_z, rsp_plane_offset;
   logic               rsp_degenerate;

   plane_type pending_planes[$];
   int        mismatches = 0;
   bit        gaps_on = 1;

   localparam logic signed [31:0] MAXV = 32'sh7FFFFFFF;
   localparam logic signed [31:0] MINV = 32'sh80000000;
   localparam logic signed [31:0] ONE  = 32'sh00010000;

   triangle_plane_hessian_form dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_a_x(req_a_x), .req_a_y(req_a_y), .req_a_z(req_a_z),
      .req_b_x(req_b_x), .req_b_y(req_b_y), .req_b_z(req_b_z),
      .req_c_x(req_c_x), .req_c_y(req_c_y), .req_c_z(req_c_z),
      .rsp_strobe(rsp_strobe), .rsp_normal_x(rsp_normal_x),
      .rsp_normal_y(rsp_normal_y), .rsp_normal_z(rsp_normal_z),
      .rsp_plane_offset(rsp_plane_offset), .rsp_degenerate(rsp_degenerate)
   );

   always #5 clock = ~clock;

   function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x = x - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic plane_type solve_plane(triangle_type t);
      plane_type          p;
      logic signed [67:0] a [3];
      logic signed [67:0] e1 [3];
      logic signed [67:0] e2 [3];
      logic signed [67:0] n [3];
      logic [67:0]        mg [3];
      logic [67:0]        sh;
      logic [63:0]        v [3];
      logic [63:0]        s, root, q, mag, m;
      longint             u [3];
      longint             acc;
      int                 len;
      len = 0;
      for (int i = 0; i < 3; i++) begin
         a[i] = t.v[i];
         e1[i] = 68'(t.v[3+i]) - a[i];
         e2[i] = 68'(t.v[6+i]) - a[i];
      end
      n[0] = e1[1] * e2[2] - e1[2] * e2[1];
      n[1] = e1[2] * e2[0] - e1[0] * e2[2];
      n[2] = e1[0] * e2[1] - e1[1] * e2[0];
      for (int i = 0; i < 3; i++) begin
         mg[i] = n[i] < 0 ? -n[i] : n[i];
         for (int b = 67; b >= 0; b--)
            if (mg[i][b] && b + 1 > len) begin
               len = b + 1;
               break;
            end
      end
      if (len == 0) begin
         p.nx = 0; p.ny = 0; p.nz = 0; p.offset = 0; p.deg = 1;
         return p;
      end
      s = 0;
      for (int i = 0; i < 3; i++) begin
         sh = len > 31 ? mg[i] >> (len - 31) : mg[i] << (31 - len);
         v[i] = {33'd0, sh[30:0]};
         s = s + v[i] * v[i];
      end
      root = int_sqrt(s);
      for (int i = 0; i < 3; i++) begin
         q = ((v[i] << 30) + (root >> 1)) / root;
         u[i] = n[i] < 0 ? -longint'(q) : longint'(q);
      end
      p.nx = u[0][31:0]; p.ny = u[1][31:0]; p.nz = u[2][31:0];
      acc = longint'(t.v[0]) * u[0] + longint'(t.v[1]) * u[1] + longint'(t.v[2]) * u[2];
      mag = acc < 0 ? -acc : acc;
      m = (mag + (64'd1 << 29)) >> 30;
      // d is the negated dot product, so a negative sum gives a positive offset
      if (acc < 0) begin
         if (m > 64'h7FFFFFFF) m = 64'h7FFFFFFF;
         p.offset = m[31:0];
      end else begin
         if (m > 64'h80000000) m = 64'h80000000;
         p.offset = -m[31:0];
      end
      p.deg = 0;
      return p;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
      mismatches++;
   endtask

   // drive one word and hold it until the unit takes it
   task automatic send_triangle(triangle_type t);
      while (gaps_on && $urandom_range(99) < 9) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      {req_a_x, req_a_y, req_a_z} <= {t.v[0], t.v[1], t.v[2]};
      {req_b_x, req_b_y, req_b_z} <= {t.v[3], t.v[4], t.v[5]};
      {req_c_x, req_c_y, req_c_z} <= {t.v[6], t.v[7], t.v[8]};
      do @(posedge clock); while (busy);
      pending_planes.push_back(solve_plane(t));
   endtask

   always @(posedge clock) begin
      plane_type want;
      if (!reset && rsp_strobe) begin
         if (pending_planes.size() == 0) begin
            report_mismatch("unexpected word", rsp_normal_x, '0);
         end else begin
            want = pending_planes.pop_front();
            if (rsp_normal_x !== want.nx) report_mismatch("normal_x", rsp_normal_x, want.nx);
            if (rsp_normal_y !== want.ny) report_mismatch("normal_y", rsp_normal_y, want.ny);
            if (rsp_normal_z !== want.nz) report_mismatch("normal_z", rsp_normal_z, want.nz);
            if (rsp_plane_offset !== want.offset)
               report_mismatch("plane_offset", rsp_plane_offset, want.offset);
            if (rsp_degenerate !== want.deg)
               report_mismatch("degenerate", rsp_degenerate, want.deg);
         end
      end
   end

   function automatic triangle_type make_tri(logic signed [31:0] ax, ay, az, bx, by, bz,
                                             cx, cy, cz);
      triangle_type t;
      t.v = '{ax, ay, az, bx, by, bz, cx, cy, cz};
      return t;
   endfunction

   function automatic triangle_type random_tri(int kind);
      triangle_type t;
      logic [31:0]  d [3];
      int           k;
      for (int i = 0; i < 9; i++) t.v[i] = $urandom;
      case (kind)
         0: ;  // full-range noise
         1: begin
            for (int i = 0; i < 9; i++) t.v[i] = $signed($urandom_range(2047)) - 1024;
         end
         2: begin
            // collinear or coincident: b = a + d, c = a + k*d
            k = $urandom_range(3);
            for (int i = 0; i < 3; i++) begin
               d[i] = $signed($urandom_range(65535)) - 32768;
               t.v[i] = $signed($urandom_range(32'h3FFFFFFF)) - 32'sh20000000;
               t.v[3+i] = t.v[i] + d[i];
               t.v[6+i] = t.v[i] + k * d[i];
            end
         end
         default: begin
            // small triangle far from the origin, pushes the offset to its limits
            for (int i = 0; i < 3; i++) begin
               t.v[3+i] = t.v[i] + ($signed($urandom_range(255)) - 128);
               t.v[6+i] = t.v[i] + ($signed($urandom_range(255)) - 128);
            end
         end
      endcase
      return t;
   endfunction

   task automatic test_extremes();
      send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_triangle(make_tri(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV));
      send_triangle(make_tri(MINV, MINV, MINV, MAXV, MINV, MINV, MINV, MAXV, MINV));
      send_triangle(make_tri(MAXV, MAXV, MAXV, MINV, MAXV, MAXV, MAXV, MINV, MAXV));
      send_triangle(make_tri(MINV, MAXV, MINV, MAXV, MINV, MAXV, MAXV, MAXV, MINV));
      send_triangle(make_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0));
      send_triangle(make_tri(0, 0, 0, 0, ONE, 0, ONE, 0, 0));
      send_triangle(make_tri(0, 0, 0, 1, 0, 0, 0, 0, 1));
      send_triangle(make_tri(0, 0, 0, 1, 1, 0, 0, 1, 1));
      send_triangle(make_tri(-1, -1, -1, -1, -1, -1, -1, -1, -1));
   endtask

   task automatic test_degenerate();
      send_triangle(make_tri(5, 6, 7, 5, 6, 7, 9, 9, 9));
      send_triangle(make_tri(0, 0, 0, ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE));
      send_triangle(make_tri(MINV, MINV, MINV, 0, 0, 0, MAXV, MAXV, MAXV - 1));
      send_triangle(make_tri(MINV, 0, MAXV, MINV, 0, MAXV, MINV, 0, MAXV));
   endtask

   task automatic test_offset_saturation();
      logic signed [31:0] k;
      k = ONE;
      // plane z = const, offset = -z for normal +z and +z for normal -z
      send_triangle(make_tri(0, 0, MINV, ONE, 0, MINV, 0, ONE, MINV));
      send_triangle(make_tri(0, 0, MAXV, ONE, 0, MAXV, 0, ONE, MAXV));
      send_triangle(make_tri(0, 0, MINV, 0, ONE, MINV, ONE, 0, MINV));
      // normal along (-1,1,1) or (1,-1,-1): |d| is about the coordinate divided by sqrt(3)
      send_triangle(make_tri(MAXV, MAXV, MAXV, MAXV - k, MAXV, MAXV - k,
                             MAXV - k, MAXV - k, MAXV));
      send_triangle(make_tri(MAXV, MAXV, MAXV, MAXV - k, MAXV - k, MAXV,
                             MAXV - k, MAXV, MAXV - k));
      send_triangle(make_tri(MINV, MINV, MINV, MINV + k, MINV, MINV + k,
                             MINV + k, MINV + k, MINV));
      send_triangle(make_tri(MINV, MINV, MINV, MINV + k, MINV + k, MINV,
                             MINV + k, MINV, MINV + k));
   endtask

   task automatic test_drain_pause();
      for (int i = 0; i < 6; i++) send_triangle(random_tri(i % 4));
      start <= 0;
      wait (pending_planes.size() == 0);
      @(posedge clock);
      for (int i = 0; i < 6; i++) send_triangle(random_tri(i % 4));
   endtask

   task automatic test_random();
      for (int i = 0; i < 500; i++) begin
         // back-to-back stretch in the middle
         gaps_on = !(i >= 150 && i < 260);
         send_triangle(random_tri($urandom_range(3)));
      end
      gaps_on = 1;
   endtask

   initial begin
      clock = 0;
      reset = 1;
      start = 0;
      {req_a_x, req_a_y, req_a_z, req_b_x, req_b_y, req_b_z} = '0;
      {req_c_x, req_c_y, req_c_z} = '0;
      repeat (4) @(posedge clock);
      reset <= 0;
      test_extremes();
      test_degenerate();
      test_offset_saturation();
      test_drain_pause();
      test_random();
      start <= 0;
      wait (pending_planes.size() == 0);
      repeat (tphf_pkg::LATENCY + 20) @(posedge clock);
      if (mismatches == 0) begin
         $display("triangle_plane_hessian_form_tb passed");
      end else begin
         $display("triangle_plane_hessian_form_tb failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("triangle_plane_hessian_form_tb failed");
      $finish;
   end

endmodule

[sim.f]
src/tphf_pkg.sv
src/tphf_sqrt.sv
src/tphf_div.sv
src/triangle_plane_hessian_form.sv
test/triangle_plane_hessian_form_tb.sv
